/* src/tms_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the triangle midpoint subdivider.
// No dependencies.
package tms_pkg;

   localparam int unsigned MAX_VERTICES_DEF = 4096;
   localparam int unsigned EDGE_SLOTS_DEF   = 8192;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_TRI   = 2'd2;

   localparam logic [2:0] KIND_POS  = 3'd0;
   localparam logic [2:0] KIND_NORM = 3'd1;
   localparam logic [2:0] KIND_TEX  = 3'd2;
   localparam logic [2:0] KIND_TRI  = 3'd3;
   localparam logic [2:0] KIND_ERR  = 3'd4;

   localparam logic CSR_HAS_NORMALS   = 1'b0;
   localparam logic CSR_HAS_TEXCOORDS = 1'b1;

   // One vertex record, all components signed Q16.16
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic signed [31:0] norm_z;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
   } vtx_type;

endpackage

/* src/tms_midpoint.sv */
`timescale 1ns / 1ps
// Midpoint of two vertex records: per component halved 33-bit sum.
// Depends on tms_pkg.
module tms_midpoint
   import tms_pkg::*;
(
   input  vtx_type v0,
   input  vtx_type v1,
   output vtx_type mid
);

   function automatic logic signed [31:0] half_sum(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic [32:0] s;
      s = {a[31], a} + {b[31], b};
      return $signed(s[32:1]);
   endfunction

   always_comb begin
      mid.pos_x  = half_sum(v0.pos_x,  v1.pos_x);
      mid.pos_y  = half_sum(v0.pos_y,  v1.pos_y);
      mid.pos_z  = half_sum(v0.pos_z,  v1.pos_z);
      mid.norm_x = half_sum(v0.norm_x, v1.norm_x);
      mid.norm_y = half_sum(v0.norm_y, v1.norm_y);
      mid.norm_z = half_sum(v0.norm_z, v1.norm_z);
      mid.tex_u  = half_sum(v0.tex_u,  v1.tex_u);
      mid.tex_v  = half_sum(v0.tex_v,  v1.tex_v);
   end

endmodule

/* src/triangle_midpoint_subdivider_core.sv */
`timescale 1ns / 1ps
// Top level of the 1-to-4 midpoint triangle subdivider: vertex store, edge
// hash table and sequencer. Depends on tms_pkg and tms_midpoint.
//
// Busy is high after reset and after every start item while the edge table
// is swept clear, one slot a cycle, and no new item is accepted while busy
// is high. A triangle item, per edge, hashes the edge, probes slots in the
// edge table until it finds the edge or a free slot, and writes a new
// midpoint for a new edge; then it reads each edge's midpoint in turn, gives
// one to three result items per new midpoint and four triangle items.
// Results come on rsp_strobe and cannot be held off. A failed triangle
// undoes each edge entry it added, then gives the error item.
// EDGE_SLOTS must be a power of two.
module triangle_midpoint_subdivider_core
   import tms_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int unsigned EDGE_SLOTS   = EDGE_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_norm_x,
   input  logic signed [31:0] req_norm_y,
   input  logic signed [31:0] req_norm_z,
   input  logic signed [31:0] req_tex_u,
   input  logic signed [31:0] req_tex_v,
   input  logic [11:0]        req_corner_a,
   input  logic [11:0]        req_corner_b,
   input  logic [11:0]        req_corner_c,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_kind,
   output logic signed [31:0] rsp_comp_a,
   output logic signed [31:0] rsp_comp_b,
   output logic signed [31:0] rsp_comp_c,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic               csr_wdata
);

   localparam int VIW  = $clog2(MAX_VERTICES);
   localparam int CNTW = VIW + 1;
   localparam int EW   = $clog2(EDGE_SLOTS);
   localparam int ENTW = 1 + 3 * VIW;
   localparam int HW   = VIW + 6;
   localparam int CMPW = (CNTW > 12) ? CNTW : 12;

   typedef enum logic [10:0] {
      ST_CLEAR = 11'b00000000001,
      ST_IDLE  = 11'b00000000010,
      ST_HASH  = 11'b00000000100,
      ST_PROBE = 11'b00000001000,
      ST_MIDW  = 11'b00000010000,
      ST_UNDO  = 11'b00000100000,
      ST_RDMID = 11'b00001000000,
      ST_OPOS  = 11'b00010000000,
      ST_ONORM = 11'b00100000000,
      ST_OTEX  = 11'b01000000000,
      ST_TRI   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CNTW-1:0] count_ff, count_in, saved_ff, saved_in;
   logic [EW-1:0]   clr_ff, clr_in, slot_ff, slot_in, pcnt_ff, pcnt_in;
   logic [VIW-1:0]  ca_ff, ca_in, cb_ff, cb_in, cc_ff, cc_in;
   logic [1:0]      eidx_ff, eidx_in, oidx_ff, oidx_in, nadd_ff, nadd_in;
   logic [VIW-1:0]  mid_ff [3];
   logic [VIW-1:0]  mid_in [3];
   logic [2:0]      new_ff, new_in;
   logic [EW-1:0]   added_ff [3];
   logic [EW-1:0]   added_in [3];
   logic            has_n_ff, has_t_ff;

   logic            rsp_strobe_ff, rsp_strobe_in, rsp_last_ff, rsp_last_in;
   logic [2:0]      rsp_kind_ff, rsp_kind_in;
   logic [31:0]     rsp_a_ff, rsp_a_in, rsp_b_ff, rsp_b_in, rsp_c_ff, rsp_c_in;

   // memories
   vtx_type         vmem [MAX_VERTICES];
   vtx_type         vrd0_ff, vrd1_ff, vwdata, vmid;
   logic [VIW-1:0]  vra0, vra1, vwaddr;
   logic            vwe;
   logic [ENTW-1:0] emem [EDGE_SLOTS];
   logic [ENTW-1:0] erd_ff, ewdata;
   logic [EW-1:0]   era, ewaddr;
   logic            ewe;

   logic            accept;
   logic [VIW-1:0]  ev0, ev1, key_lo, key_hi;
   logic [HW-1:0]   hval;
   logic [EW-1:0]   hslot;
   logic            ent_valid, ent_match, vfull;
   logic [VIW-1:0]  ent_mid;
   logic            corner_bad;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         has_n_ff <= 1'b0;
         has_t_ff <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_HAS_NORMALS) has_n_ff <= csr_wdata;
         if (csr_index == CSR_HAS_TEXCOORDS) has_t_ff <= csr_wdata;
      end
   end

   // edge endpoints: AB, BC, CA
   always_comb begin
      unique case (eidx_ff)
         2'd0:    begin ev0 = ca_ff; ev1 = cb_ff; end
         2'd1:    begin ev0 = cb_ff; ev1 = cc_ff; end
         default: begin ev0 = cc_ff; ev1 = ca_ff; end
      endcase
      key_lo = (ev0 < ev1) ? ev0 : ev1;
      key_hi = (ev0 < ev1) ? ev1 : ev0;
      hval   = (HW'(key_lo) << 5) - HW'(key_lo) + HW'(key_hi);
      hslot  = EW'(hval);
   end

   assign ent_valid = erd_ff[ENTW-1];
   assign ent_match = (erd_ff[3*VIW-1:2*VIW] == key_lo) && (erd_ff[2*VIW-1:VIW] == key_hi);
   assign ent_mid   = erd_ff[VIW-1:0];
   assign vfull     = (count_ff >= CNTW'(MAX_VERTICES));
   assign corner_bad = (CMPW'(req_corner_a) >= CMPW'(count_ff))
                    || (CMPW'(req_corner_b) >= CMPW'(count_ff))
                    || (CMPW'(req_corner_c) >= CMPW'(count_ff));

   tms_midpoint u_mid (
      .v0  (vrd0_ff),
      .v1  (vrd1_ff),
      .mid (vmid)
   );

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      saved_in  = saved_ff;
      clr_in    = clr_ff;
      slot_in   = slot_ff;
      pcnt_in   = pcnt_ff;
      ca_in     = ca_ff;
      cb_in     = cb_ff;
      cc_in     = cc_ff;
      eidx_in   = eidx_ff;
      oidx_in   = oidx_ff;
      nadd_in   = nadd_ff;
      mid_in    = mid_ff;
      new_in    = new_ff;
      added_in  = added_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = KIND_ERR;
      rsp_a_in      = '0;
      rsp_b_in      = '0;
      rsp_c_in      = '0;
      rsp_last_in   = 1'b1;
      vwe    = 1'b0;
      vwaddr = mid_ff[eidx_ff];
      vwdata = vmid;
      vra0   = mid_ff[oidx_ff];
      vra1   = ev1;
      ewe    = 1'b0;
      ewaddr = slot_ff;
      ewdata = '0;
      era    = hslot;

      unique case (state_ff)
         ST_CLEAR: begin
            ewe    = 1'b1;
            ewaddr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == EW'(EDGE_SLOTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_START: begin
                     count_in = '0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_LOAD: begin
                     if (vfull) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        vwe    = 1'b1;
                        vwaddr = count_ff[VIW-1:0];
                        vwdata = '{req_pos_x, req_pos_y, req_pos_z, req_norm_x,
                                   req_norm_y, req_norm_z, req_tex_u, req_tex_v};
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_TRI: begin
                     if (corner_bad) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        ca_in    = VIW'(req_corner_a);
                        cb_in    = VIW'(req_corner_b);
                        cc_in    = VIW'(req_corner_c);
                        saved_in = count_ff;
                        eidx_in  = 2'd0;
                        nadd_in  = 2'd0;
                        new_in   = 3'b000;
                        state_in = ST_HASH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_HASH: begin
            era      = hslot;
            slot_in  = hslot;
            pcnt_in  = '0;
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            vra0 = ev0;
            if (ent_valid && ent_match) begin
               mid_in[eidx_ff] = ent_mid;
               if (eidx_ff == 2'd2) begin
                  oidx_in  = 2'd0;
                  state_in = ST_RDMID;
               end else begin
                  eidx_in  = eidx_ff + 1'b1;
                  state_in = ST_HASH;
               end
            end else if (ent_valid) begin
               if (pcnt_ff == EW'(EDGE_SLOTS - 1)) begin
                  state_in = ST_UNDO;
               end else begin
                  pcnt_in  = pcnt_ff + 1'b1;
                  slot_in  = slot_ff + 1'b1;
                  era      = slot_ff + 1'b1;
               end
            end else if (vfull) begin
               state_in = ST_UNDO;
            end else begin
               // claim the slot and allocate the midpoint vertex
               ewe      = 1'b1;
               ewaddr   = slot_ff;
               ewdata   = {1'b1, key_lo, key_hi, count_ff[VIW-1:0]};
               added_in[nadd_ff] = slot_ff;
               nadd_in  = nadd_ff + 1'b1;
               mid_in[eidx_ff] = count_ff[VIW-1:0];
               new_in[eidx_ff] = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = ST_MIDW;
            end
         end
         ST_MIDW: begin
            vwe = 1'b1;
            if (eidx_ff == 2'd2) begin
               oidx_in  = 2'd0;
               state_in = ST_RDMID;
            end else begin
               eidx_in  = eidx_ff + 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_UNDO: begin
            if (nadd_ff == 2'd0) begin
               count_in      = saved_ff;
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               ewe     = 1'b1;
               ewaddr  = added_ff[nadd_ff - 1'b1];
               nadd_in = nadd_ff - 1'b1;
            end
         end
         ST_RDMID: begin
            if (oidx_ff == 2'd3) begin
               oidx_in  = 2'd0;
               state_in = ST_TRI;
            end else if (new_ff[oidx_ff]) begin
               state_in = ST_OPOS;
            end else begin
               oidx_in = oidx_ff + 1'b1;
            end
         end
         ST_OPOS: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = KIND_POS;
            rsp_a_in      = vrd0_ff.pos_x;
            rsp_b_in      = vrd0_ff.pos_y;
            rsp_c_in      = vrd0_ff.pos_z;
            rsp_last_in   = 1'b0;
            if (has_n_ff) state_in = ST_ONORM;
            else if (has_t_ff) state_in = ST_OTEX;
            else begin
               oidx_in  = oidx_ff + 1'b1;
               state_in = ST_RDMID;
            end
         end
         ST_ONORM: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = KIND_NORM;
            rsp_a_in      = vrd0_ff.norm_x;
            rsp_b_in      = vrd0_ff.norm_y;
            rsp_c_in      = vrd0_ff.norm_z;
            rsp_last_in   = 1'b0;
            if (has_t_ff) state_in = ST_OTEX;
            else begin
               oidx_in  = oidx_ff + 1'b1;
               state_in = ST_RDMID;
            end
         end
         ST_OTEX: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = KIND_TEX;
            rsp_a_in      = vrd0_ff.tex_u;
            rsp_b_in      = vrd0_ff.tex_v;
            rsp_last_in   = 1'b0;
            oidx_in       = oidx_ff + 1'b1;
            state_in      = ST_RDMID;
         end
         ST_TRI: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = KIND_TRI;
            rsp_last_in   = 1'b0;
            unique case (oidx_ff)
               2'd0: begin
                  rsp_a_in = 32'(ca_ff); rsp_b_in = 32'(mid_ff[0]); rsp_c_in = 32'(mid_ff[2]);
               end
               2'd1: begin
                  rsp_a_in = 32'(cb_ff); rsp_b_in = 32'(mid_ff[1]); rsp_c_in = 32'(mid_ff[0]);
               end
               2'd2: begin
                  rsp_a_in = 32'(cc_ff); rsp_b_in = 32'(mid_ff[2]); rsp_c_in = 32'(mid_ff[1]);
               end
               default: begin
                  rsp_a_in    = 32'(mid_ff[0]);
                  rsp_b_in    = 32'(mid_ff[1]);
                  rsp_c_in    = 32'(mid_ff[2]);
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            endcase
            oidx_in = oidx_ff + 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         nadd_ff       <= '0;
         new_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         nadd_ff       <= nadd_in;
         new_ff        <= new_in;
      end
   end

   // payload and indices
   always_ff @(posedge clock) begin
      saved_ff    <= saved_in;
      slot_ff     <= slot_in;
      pcnt_ff     <= pcnt_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      cc_ff       <= cc_in;
      eidx_ff     <= eidx_in;
      oidx_ff     <= oidx_in;
      mid_ff      <= mid_in;
      added_ff    <= added_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_a_ff    <= rsp_a_in;
      rsp_b_ff    <= rsp_b_in;
      rsp_c_ff    <= rsp_c_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (vwe) vmem[vwaddr] <= vwdata;
      vrd0_ff <= vmem[vra0];
      vrd1_ff <= vmem[vra1];
   end

   always_ff @(posedge clock) begin
      if (ewe) emem[ewaddr] <= ewdata;
      erd_ff <= emem[era];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_comp_a = $signed(rsp_a_ff);
   assign rsp_comp_b = $signed(rsp_b_ff);
   assign rsp_comp_c = $signed(rsp_c_ff);
   assign rsp_last   = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_VERTICES))
      else $error("vertex count beyond store depth");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind == KIND_ERR |-> rsp_last)
      else $error("error result without last");
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_command == CMD_START |=> busy && count_ff == '0)
      else $error("start did not begin table sweep");
   a_undo_restores: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UNDO && nadd_ff == 2'd0 |=> count_ff == $past(saved_ff))
      else $error("vertex count not restored after failed triangle");
`endif

endmodule
